FILE: hdl/apq_pkg.sv
// shared types and constants for the aging priority queue
package apq_pkg;

    localparam int AGE_W = 32;

    typedef enum logic
    {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } op_t;

    typedef struct packed
    {
        logic load;
        logic compare;
        logic apply;
    } dp_cmd_t;

endpackage

FILE: hdl/apq_ctrl.sv
// sequencing state machine for the aging priority queue
module apq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output apq_pkg::dp_cmd_t  cmd
);
    import apq_pkg::*;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_COMPARE,
        ST_APPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply    = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: hdl/apq_datapath.sv
// entry cells, per-cell compare flags and result registers
module apq_datapath
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  apq_pkg::dp_cmd_t               cmd,
    input  logic                           item_command,
    input  logic signed [VALUE_WIDTH-1:0]  item_value,
    output logic                           accepted,
    output logic                           full_res,
    output logic                           popped_valid,
    output logic signed [VALUE_WIDTH-1:0]  popped_value,
    output logic                           empty_res
);
    import apq_pkg::*;

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DIFF_W = VALUE_WIDTH + AGE_W + 1;
    localparam int LVLS   = $clog2(QUEUE_DEPTH);

    logic                          command_reg;
    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic signed [VALUE_WIDTH-1:0] val_reg [QUEUE_DEPTH];
    logic        [AGE_W-1:0]       age_reg [QUEUE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] val_next [QUEUE_DEPTH];
    logic        [AGE_W-1:0]       age_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]        ge_reg;
    logic [QUEUE_DEPTH-1:0]        ge_next;
    logic [QUEUE_DEPTH-1:0]        eq_reg;
    logic [QUEUE_DEPTH-1:0]        eq_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;

    logic                          accepted_reg;
    logic                          full_reg;
    logic                          popped_valid_reg;
    logic signed [VALUE_WIDTH-1:0] popped_value_reg;
    logic                          empty_reg;

    logic                          is_enq;
    logic                          pass;
    logic                          is_full;
    logic                          do_ins;
    logic                          do_pop;
    logic [QUEUE_DEPTH-1:0]        hit;
    logic [QUEUE_DEPTH-1:0]        at_or_after;
    logic signed [DIFF_W-1:0]      new_ext;
    logic signed [DIFF_W-1:0]      diff [QUEUE_DEPTH];

    // per-cell priority and duplicate compare
    always_comb
    begin
        new_ext = DIFF_W'(value_reg);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            diff[i]    = DIFF_W'(val_reg[i]) - $signed({{(DIFF_W-AGE_W){1'b0}}, age_reg[i]});
            ge_next[i] = (CNT_W'(i) < count_reg) && (diff[i] >= new_ext);
            eq_next[i] = (CNT_W'(i) < count_reg) && (val_reg[i] == value_reg);
        end
    end

    // insertion point: first cell whose priority passes, else the tail
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            hit[i] = ge_reg[i] || (CNT_W'(i) == count_reg);
        end
        at_or_after = hit;
        for (int l = 0; l < LVLS; l++)
        begin
            at_or_after = at_or_after | (at_or_after << (1 << l));
        end
    end

    assign is_enq  = (op_t'(command_reg) == CMD_ENQUEUE);
    assign pass    = value_reg[0] || !(|eq_reg);
    assign is_full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_ins  = is_enq && pass && !is_full;
    assign do_pop  = !is_enq && (count_reg != '0);

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            val_next[i] = val_reg[i];
            age_next[i] = age_reg[i];
        end
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + 1'b1;
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (!at_or_after[i])
                begin
                    val_next[i] = val_reg[i];
                    age_next[i] = (age_reg[i] == '1) ? age_reg[i] : age_reg[i] + 1'b1;
                end
                else if (i == 0 || !at_or_after[(i == 0) ? 0 : i - 1])
                begin
                    val_next[i] = value_reg;
                    age_next[i] = AGE_W'(1);
                end
                else
                begin
                    val_next[i] = val_reg[(i == 0) ? 0 : i - 1];
                    age_next[i] = (age_reg[(i == 0) ? 0 : i - 1] == '1) ?
                                  age_reg[(i == 0) ? 0 : i - 1] :
                                  age_reg[(i == 0) ? 0 : i - 1] + 1'b1;
                end
            end
        end
        else if (do_pop)
        begin
            count_next = count_reg - 1'b1;
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                val_next[i] = val_reg[i + 1];
                age_next[i] = age_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.apply)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= item_command;
            value_reg   <= item_value;
        end
        if (cmd.compare)
        begin
            ge_reg <= ge_next;
            eq_reg <= eq_next;
        end
        if (cmd.apply)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                val_reg[i] <= val_next[i];
                age_reg[i] <= age_next[i];
            end
            accepted_reg     <= do_ins;
            full_reg         <= is_enq && pass && is_full;
            popped_valid_reg <= do_pop;
            popped_value_reg <= do_pop ? val_reg[0] : '0;
            empty_reg        <= (count_next == '0);
        end
    end

    assign accepted     = accepted_reg;
    assign full_res     = full_reg;
    assign popped_valid = popped_valid_reg;
    assign popped_value = popped_value_reg;
    assign empty_res    = empty_reg;

endmodule

FILE: hdl/aging_priority_queue_core.sv
// top level of the aging priority queue
//
//  channel  | direction | carries
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | one command word: enqueue a value or dequeue the head
//  m_axis   | out       | one result word per command word
//
// each word passes through capture, a parallel compare over all cells,
// then the shift/insert update that also loads the result register
// a new word is taken once the previous word has been applied and its result
// is being taken or the result register is empty
// reset clears the entry count and all handshake state; entries need no reset
module aging_priority_queue_core
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // value
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,
    // command
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // accepted, full_res, popped_valid, popped_value, empty_res
    output logic [((VALUE_WIDTH+4+7)/8)*8-1:0]  m_tdata
);
    import apq_pkg::*;

    localparam int OUT_W = ((VALUE_WIDTH + 4 + 7) / 8) * 8;

    dp_cmd_t                       cmd;
    logic                          accepted;
    logic                          full_res;
    logic                          popped_valid;
    logic signed [VALUE_WIDTH-1:0] popped_value;
    logic                          empty_res;

    apq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    apq_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item_command (s_tuser),
        .item_value   (s_tdata[VALUE_WIDTH-1:0]),
        .accepted     (accepted),
        .full_res     (full_res),
        .popped_valid (popped_valid),
        .popped_value (popped_value),
        .empty_res    (empty_res)
    );

    assign m_tdata = OUT_W'({empty_res, popped_value, popped_valid, full_res, accepted});

endmodule
